// ----- rtl/nps_pkg.sv -----
// ----------------------------------------------------------------------------
// nps_pkg
// Shared types and constants for the nearest point search block.
// ----------------------------------------------------------------------------
package nps_pkg;

  localparam int COORD_W = 16;  // signed Q8.8 coordinate
  localparam int ID_W    = 8;
  localparam int DIST_W  = 36;  // squared distance, Q20.16
  localparam int SQ_W    = 32;  // one squared axis term
  localparam int ABS_W   = 16;  // magnitude of one axis difference
  localparam int DIFF_W  = 17;
  localparam int STAT_W  = 2;
  localparam int OSLOT_W = 4;   // slot width on the result beat
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 56;

  localparam logic [DIST_W-1:0] THRESH_RESET = 36'd6553600000;

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

  // Item kinds carried on in_tuser
  localparam logic KIND_APPEND = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

  // Which result beat to build
  typedef enum logic [1:0] {
    RES_APP_OK,
    RES_APP_FULL,
    RES_EMPTY,
    RES_QUERY
  } res_t;

  // One stored point
  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [COORD_W-1:0] z;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } point_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;   // latch the accepted input beat
    logic append_wr; // write latched point into the next free slot
    logic start;     // reset running minimum and scan index
    logic issue;     // read one slot into the distance pipeline
    logic load_out;  // load the result register
    res_t res;       // which result to build
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic kind;       // kind of the latched item
    logic tbl_empty;
    logic tbl_full;
    logic scan_last;  // current scan index is the last stored slot
    logic pipe_busy;  // distance pipeline still holds a slot
    logic out_free;   // result register can take a new beat
  } stat_t;

endpackage

// ----- rtl/nearest_point_search.sv -----
// Query: after acceptance the item is dispatched, the table is scanned with one
// table read per cycle, the distance pipeline drains and the result register is
// loaded; an append or empty-table query goes from dispatch to the result load. One
// item is in work at a time; the next beat is taken while a result waits.
// Synchronous rst_n empties the table, zeroes the winner slot and restores the
// 100000.0 (Q20.16) threshold; the memory is not cleared.
// ----------------------------------------------------------------------------
// nearest_point_search
// Brute-force nearest neighbor over a table of 3D Q8.8 points, squared
// Euclidean distance, with append and query beats on one stream.
// ----------------------------------------------------------------------------
module nearest_point_search
  import nps_pkg::*;
#(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // pos_x, pos_y, pos_z, point_id
  input  logic                  in_tuser,   // kind
  // Result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // status, found, winner_slot,
                                            // winner_id, winner_distance
  // Threshold register
  input  logic                  cfg_wr_en,
  input  logic [DIST_W-1:0]     cfg_wr_data
);

  cmd_t  cmd;
  stat_t stat;

  nps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  nps_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

endmodule

// ----- rtl/nps_ctrl.sv -----
// ----------------------------------------------------------------------------
// nps_ctrl
// Sequencer for the nearest point search: accepts one beat, dispatches
// append or query, steps the table scan and hands the result to the output.
// ----------------------------------------------------------------------------
module nps_ctrl
  import nps_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_tvalid,
  output logic  in_tready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_DRAIN,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  res_t   res_r, res_nxt;

  // Next state and result selection
  always_comb begin
    state_nxt = state_r;
    res_nxt   = res_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_DISPATCH;
      end
      S_DISPATCH: begin
        if (stat.kind == KIND_APPEND) begin
          res_nxt   = stat.tbl_full ? RES_APP_FULL : RES_APP_OK;
          state_nxt = S_DONE;
        end else if (stat.tbl_empty) begin
          res_nxt   = RES_EMPTY;
          state_nxt = S_DONE;
        end else begin
          res_nxt   = RES_QUERY;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.scan_last) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        if (!stat.pipe_busy) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered result code
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      res_r   <= RES_APP_OK;
    end else begin
      state_r <= state_nxt;
      res_r   <= res_nxt;
    end
  end

  // Commands decoded from state
  assign in_tready     = (state_r == S_IDLE);
  assign cmd.capture   = (state_r == S_IDLE) && in_tvalid;
  assign cmd.append_wr = (state_r == S_DISPATCH) && (stat.kind == KIND_APPEND) &&
                         !stat.tbl_full;
  assign cmd.start     = (state_r == S_DISPATCH) && (stat.kind == KIND_QUERY) &&
                         !stat.tbl_empty;
  assign cmd.issue     = (state_r == S_SCAN);
  assign cmd.load_out  = (state_r == S_DONE) && stat.out_free;
  assign cmd.res       = res_r;

endmodule

// ----- rtl/nps_dp.sv -----
// ----------------------------------------------------------------------------
// nps_dp
// Datapath: point table memory, squared distance pipeline, running minimum,
// threshold register and the result output register.
// ----------------------------------------------------------------------------
module nps_dp
  import nps_pkg::*;
#(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  output stat_t                 stat,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tuser,
  input  logic                  cfg_wr_en,
  input  logic [DIST_W-1:0]     cfg_wr_data,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam int SLOT_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(TABLE_DEPTH);

  // Configuration register
  logic [DIST_W-1:0] thresh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= THRESH_RESET;
    end else if (cfg_wr_en) begin
      thresh_r <= cfg_wr_data;
    end
  end

  // Latched input beat
  point_t item_r;
  logic   kind_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= point_t'(in_tdata);
      kind_r <= in_tuser;
    end
  end

  // Table state
  logic [CNT_W-1:0]  count_r;
  logic [SLOT_W-1:0] scan_idx_r;
  logic [SLOT_W-1:0] win_slot_r;
  logic [ID_W-1:0]   win_id_r;
  point_t            mem [TABLE_DEPTH];
  point_t            rd_r;

  // Memory: one write port for appends, one registered read port for the scan
  always_ff @(posedge clk) begin
    if (cmd.append_wr) begin
      mem[count_r[SLOT_W-1:0]] <= item_r;
    end
    if (cmd.issue) begin
      rd_r <= mem[scan_idx_r];
    end
  end

  // Fill count and scan index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      scan_idx_r <= '0;
    end else begin
      if (cmd.append_wr) count_r <= count_r + 1'b1;
      if (cmd.start) begin
        scan_idx_r <= '0;
      end else if (cmd.issue) begin
        scan_idx_r <= scan_idx_r + 1'b1;
      end
    end
  end

  // Pipeline valid bits and slot tags
  logic              v1_r, v2_r, v3_r;
  logic [SLOT_W-1:0] slot1_r, slot2_r, slot3_r;
  logic [ID_W-1:0]   id2_r, id3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= cmd.issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // Stage 2: absolute axis differences
  logic signed [DIFF_W-1:0] dx, dy, dz;
  logic [ABS_W-1:0]         ax_r, ay_r, az_r;

  always_comb begin
    dx = $signed({item_r.x[COORD_W-1], item_r.x}) - $signed({rd_r.x[COORD_W-1], rd_r.x});
    dy = $signed({item_r.y[COORD_W-1], item_r.y}) - $signed({rd_r.y[COORD_W-1], rd_r.y});
    dz = $signed({item_r.z[COORD_W-1], item_r.z}) - $signed({rd_r.z[COORD_W-1], rd_r.z});
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) slot1_r <= scan_idx_r;
    ax_r    <= dx[DIFF_W-1] ? ABS_W'(-dx) : ABS_W'(dx);
    ay_r    <= dy[DIFF_W-1] ? ABS_W'(-dy) : ABS_W'(dy);
    az_r    <= dz[DIFF_W-1] ? ABS_W'(-dz) : ABS_W'(dz);
    slot2_r <= slot1_r;
    id2_r   <= rd_r.id;
  end

  // Stage 3: squares, one multiplier per axis
  logic [SQ_W-1:0] sx_r, sy_r, sz_r;

  always_ff @(posedge clk) begin
    sx_r    <= ax_r * ax_r;
    sy_r    <= ay_r * ay_r;
    sz_r    <= az_r * az_r;
    slot3_r <= slot2_r;
    id3_r   <= id2_r;
  end

  // Stage 4: sum and strict compare against the running minimum
  logic [DIST_W-1:0] sum;
  logic [DIST_W-1:0] best_r;
  logic              found_r;
  logic              better;

  assign sum    = DIST_W'(sx_r) + DIST_W'(sy_r) + DIST_W'(sz_r);
  assign better = v3_r && (sum < best_r);

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      best_r <= thresh_r;
    end else if (better) begin
      best_r <= sum;
    end
  end

  // Winner tracking; the id of slot 0 is picked up when it is first written
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_slot_r <= '0;
      found_r    <= 1'b0;
    end else begin
      if (cmd.start) begin
        found_r <= 1'b0;
      end else if (better) begin
        found_r    <= 1'b1;
        win_slot_r <= slot3_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (better) begin
      win_id_r <= id3_r;
    end else if (cmd.append_wr && (CNT_W'(win_slot_r) == count_r)) begin
      win_id_r <= item_r.id;
    end
  end

  // Result register
  logic                  out_valid_r;
  logic [STAT_W-1:0]     o_status_r, o_status_nxt;
  logic                  o_found_r, o_found_nxt;
  logic [OSLOT_W-1:0]    o_slot_r, o_slot_nxt;
  logic [ID_W-1:0]       o_id_r, o_id_nxt;
  logic [DIST_W-1:0]     o_dist_r, o_dist_nxt;

  always_comb begin
    o_status_nxt = STAT_OK;
    o_found_nxt  = 1'b0;
    o_slot_nxt   = '0;
    o_id_nxt     = '0;
    o_dist_nxt   = '0;
    case (cmd.res)
      RES_APP_OK:   o_status_nxt = STAT_OK;
      RES_APP_FULL: o_status_nxt = STAT_FULL;
      RES_EMPTY: begin
        o_status_nxt = STAT_EMPTY;
        o_slot_nxt   = OSLOT_W'(win_slot_r);
        o_dist_nxt   = thresh_r;
      end
      RES_QUERY: begin
        o_found_nxt = found_r;
        o_slot_nxt  = OSLOT_W'(win_slot_r);
        o_id_nxt    = win_id_r;
        o_dist_nxt  = best_r;
      end
      default: o_status_nxt = STAT_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      o_status_r <= o_status_nxt;
      o_found_r  <= o_found_nxt;
      o_slot_r   <= o_slot_nxt;
      o_id_r     <= o_id_nxt;
      o_dist_r   <= o_dist_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - DIST_W - ID_W - OSLOT_W - 1 - STAT_W){1'b0}},
                       o_dist_r, o_id_r, o_slot_r, o_found_r, o_status_r};

  // Status to the controller
  assign stat.kind      = kind_r;
  assign stat.tbl_empty = (count_r == '0);
  assign stat.tbl_full  = (count_r == CNT_MAX);
  assign stat.scan_last = ((CNT_W'(scan_idx_r) + 1'b1) == count_r);
  assign stat.pipe_busy = v1_r | v2_r | v3_r;
  assign stat.out_free  = !out_valid_r || out_tready;

endmodule
